### hw/rtl/fuzzy_drowsiness_risk_score_defines.svh
// Assertion macros shared by the drowsiness risk score RTL.
`ifndef FUZZY_DROWSINESS_RISK_SCORE_DEFINES_SVH
`define FUZZY_DROWSINESS_RISK_SCORE_DEFINES_SVH
`ifndef SYNTHESIS
// Checked only out of reset; uses the clk and rst of the enclosing module.
`define FDRS_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("fdrs assertion failed");
// Checked on every edge, reset included.
`define FDRS_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("fdrs assertion failed");
`else
`define FDRS_ASSERT(lbl, prop)
`define FDRS_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

### hw/rtl/fdrs_pkg.sv
// Constants for the drowsiness risk score pipeline.
package fdrs_pkg;

  parameter int INPUT_FRAC_BITS = 4;

  // Sensor lanes
  parameter int NUM_CH   = 5;
  parameter int CH_EYE   = 0;
  parameter int CH_STEER = 1;
  parameter int CH_HANDS = 2;
  parameter int CH_HEAD  = 3;
  parameter int CH_IDLE  = 4;

  // Ramp breakpoints in whole units, lane order as above
  parameter int LO_WHOLE [NUM_CH] = '{40, 20, 2, 8, 5};
  parameter int HI_WHOLE [NUM_CH] = '{60, 40, 5, 15, 10};

  parameter int Q_BITS        = 16;
  parameter int ONE_Q16       = 65536;
  parameter int GLARE_EYE_Q16 = 19661;
  parameter int GLARE_EYE_MIN = 56;
  parameter int TENTH_DEN     = 10;
  parameter int IDLE_NUM      = 4;
  parameter int IDLE_DEN      = 5;
  parameter int SCORE_SCALE   = 100;

  // Reciprocal multiply for constant division
  parameter int RECIP_SHIFT = 24;

  parameter int X_W     = 17;          // lane input incl. head magnitude
  parameter int M_W     = 17;          // membership 0..65536
  parameter int N_W     = 21;          // ramp numerator < 20 * 2^16
  parameter int EYE_W   = 7;
  parameter int SENS_W  = 16;
  parameter int SCORE_W = 7;
  parameter int STAGES  = 6;

endpackage

### hw/rtl/fdrs_sample_if.sv
// Input channel: one set of driver measurements.
interface fdrs_sample_if;
  logic                                 valid;
  logic                                 ready;
  logic [fdrs_pkg::EYE_W-1:0]           eye_closure_pct;
  logic [fdrs_pkg::SENS_W-1:0]          steer_deviation;
  logic [fdrs_pkg::SENS_W-1:0]          hands_off_time;
  logic signed [fdrs_pkg::SENS_W-1:0]   head_angle_change;
  logic [fdrs_pkg::SENS_W-1:0]          idle_time;

  modport source (
    output valid, eye_closure_pct, steer_deviation, hands_off_time,
           head_angle_change, idle_time,
    input  ready
  );
  modport sink (
    input  valid, eye_closure_pct, steer_deviation, hands_off_time,
           head_angle_change, idle_time,
    output ready
  );
endinterface

### hw/rtl/fdrs_score_if.sv
// Output channel: risk score result.
interface fdrs_score_if;
  logic                           valid;
  logic                           ready;
  logic [fdrs_pkg::SCORE_W-1:0]   risk_score;

  modport source (output valid, risk_score, input ready);
  modport sink (input valid, risk_score, output ready);
endinterface

### hw/rtl/fuzzy_drowsiness_risk_score.sv
// Drowsiness risk score: five ramp memberships, glare rule, max, scale to 0..100.
//
//   channel   dir  payload                                           handshake
//   sample    in   eye_closure_pct, steer_deviation, hands_off_time,  valid/ready
//                  head_angle_change, idle_time
//   score     out  risk_score                                        valid/ready
//
// Six register stages: compare, reciprocal multiply, correction, idle weight,
// glare and max, score scaling. One transaction per cycle while the output is taken.
// The constant-divide multipliers set the stage split. Whole pipeline holds
// when the output register is full and not taken; no bubbles are squeezed out.
// rst (synchronous) clears the valid bits only.
`include "fuzzy_drowsiness_risk_score_defines.svh"

module fuzzy_drowsiness_risk_score #(
  parameter int INPUT_FRAC_BITS = fdrs_pkg::INPUT_FRAC_BITS
) (
  input  logic                 clk,
  input  logic                 rst,
  fdrs_sample_if.sink          sample,
  fdrs_score_if.source         score
);

  localparam int NCH  = fdrs_pkg::NUM_CH;
  localparam int XW   = fdrs_pkg::X_W;
  localparam int MW   = fdrs_pkg::M_W;
  localparam int NW   = fdrs_pkg::N_W;
  localparam int QB   = fdrs_pkg::Q_BITS;
  localparam int RS   = fdrs_pkg::RECIP_SHIFT;
  localparam int PW   = NW + RS;
  localparam int AW   = MW + 2;
  localparam int PAW  = AW + RS;
  localparam int TW   = MW + 4;
  localparam int SPW  = MW + fdrs_pkg::SCORE_W;
  localparam int IDLE_RECIP = (1 << RS) / fdrs_pkg::IDLE_DEN;

  logic                      adv;
  logic [fdrs_pkg::STAGES-1:0] vld;

  assign adv          = !vld[fdrs_pkg::STAGES-1] || score.ready;
  assign sample.ready = adv;
  assign score.valid  = vld[fdrs_pkg::STAGES-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[fdrs_pkg::STAGES-2:0], sample.valid};
    end
  end

  // Lane inputs, head as magnitude
  logic [XW-1:0] x [NCH];
  logic [XW-1:0] head_mag;

  always_comb begin
    if (sample.head_angle_change[fdrs_pkg::SENS_W-1]) begin
      head_mag = XW'(fdrs_pkg::ONE_Q16) - XW'(unsigned'(sample.head_angle_change));
    end else begin
      head_mag = XW'(unsigned'(sample.head_angle_change));
    end
    x[fdrs_pkg::CH_EYE]   = XW'(sample.eye_closure_pct);
    x[fdrs_pkg::CH_STEER] = XW'(sample.steer_deviation);
    x[fdrs_pkg::CH_HANDS] = XW'(sample.hands_off_time);
    x[fdrs_pkg::CH_HEAD]  = head_mag;
    x[fdrs_pkg::CH_IDLE]  = XW'(sample.idle_time);
  end

  // Per-lane ramp pipeline, stages 1 to 3
  logic [NW-1:0] n1 [NCH];
  logic          zero1 [NCH];
  logic          sat1 [NCH];
  logic [QB-1:0] q2 [NCH];
  logic [NW-1:0] n2 [NCH];
  logic          zero2 [NCH];
  logic          sat2 [NCH];
  logic [MW-1:0] m3 [NCH];

  genvar i;
  generate
    for (i = 0; i < NCH; i++) begin : g_lane
      localparam int Sh     = (i == fdrs_pkg::CH_EYE) ? 0 : INPUT_FRAC_BITS;
      localparam int Lo     = fdrs_pkg::LO_WHOLE[i] << Sh;
      localparam int Hi     = fdrs_pkg::HI_WHOLE[i] << Sh;
      localparam int Span   = fdrs_pkg::HI_WHOLE[i] - fdrs_pkg::LO_WHOLE[i];
      localparam int Recip  = (1 << RS) / Span;
      localparam int NShift = QB - Sh;

      logic [PW-1:0] prod;
      logic [NW-1:0] rem;
      logic          corr;

      // (x - lo) * 2^16 / (Span << Sh) == ((x - lo) << (16 - Sh)) / Span
      always_ff @(posedge clk) begin
        if (adv) begin
          zero1[i] <= x[i] <= XW'(Lo);
          sat1[i]  <= x[i] >= XW'(Hi);
          n1[i]    <= NW'(x[i] - XW'(Lo)) << NShift;
        end
      end

      assign prod = PW'(n1[i]) * PW'(Recip);

      always_ff @(posedge clk) begin
        if (adv) begin
          q2[i]    <= prod[RS+QB-1:RS];
          n2[i]    <= n1[i];
          zero2[i] <= zero1[i];
          sat2[i]  <= sat1[i];
        end
      end

      // reciprocal estimate is low by at most one
      assign rem  = n2[i] - NW'(q2[i]) * NW'(Span);
      assign corr = rem >= NW'(Span);

      always_ff @(posedge clk) begin
        if (adv) begin
          if (zero2[i]) begin
            m3[i] <= '0;
          end else if (sat2[i]) begin
            m3[i] <= MW'(fdrs_pkg::ONE_Q16);
          end else begin
            m3[i] <= MW'(q2[i]) + MW'(corr);
          end
        end
      end
    end
  endgenerate

  // Glare eye condition travels with the lanes
  logic eye_hi1, eye_hi2, eye_hi3;

  always_ff @(posedge clk) begin
    if (adv) begin
      eye_hi1 <= sample.eye_closure_pct > fdrs_pkg::EYE_W'(fdrs_pkg::GLARE_EYE_MIN);
      eye_hi2 <= eye_hi1;
      eye_hi3 <= eye_hi2;
    end
  end

  // Stage 4: idle weight estimate, tenth tests
  logic [AW-1:0]  idle_a;
  logic [PAW-1:0] idle_prod;
  logic           tenth_steer, tenth_hands, tenth_head;

  assign idle_a      = AW'(m3[fdrs_pkg::CH_IDLE]) * AW'(fdrs_pkg::IDLE_NUM);
  assign idle_prod   = PAW'(idle_a) * PAW'(IDLE_RECIP);
  assign tenth_steer = TW'(m3[fdrs_pkg::CH_STEER]) * TW'(fdrs_pkg::TENTH_DEN)
                       < TW'(fdrs_pkg::ONE_Q16);
  assign tenth_hands = TW'(m3[fdrs_pkg::CH_HANDS]) * TW'(fdrs_pkg::TENTH_DEN)
                       < TW'(fdrs_pkg::ONE_Q16);
  assign tenth_head  = TW'(m3[fdrs_pkg::CH_HEAD]) * TW'(fdrs_pkg::TENTH_DEN)
                       < TW'(fdrs_pkg::ONE_Q16);

  logic [MW-1:0] m4_eye, m4_steer, m4_hands, m4_head;
  logic [QB-1:0] idle_q4;
  logic [AW-1:0] idle_a4;
  logic          glare4;

  always_ff @(posedge clk) begin
    if (adv) begin
      m4_eye   <= m3[fdrs_pkg::CH_EYE];
      m4_steer <= m3[fdrs_pkg::CH_STEER];
      m4_hands <= m3[fdrs_pkg::CH_HANDS];
      m4_head  <= m3[fdrs_pkg::CH_HEAD];
      idle_q4  <= idle_prod[RS+QB-1:RS];
      idle_a4  <= idle_a;
      glare4   <= eye_hi3 && tenth_steer && tenth_hands && tenth_head;
    end
  end

  // Stage 5: idle correction, glare override, max
  logic [AW-1:0] idle_rem;
  logic [MW-1:0] idle_m, eye_m, max_next;
  logic [MW-1:0] maxm5;

  always_comb begin
    idle_rem = idle_a4 - AW'(idle_q4) * AW'(fdrs_pkg::IDLE_DEN);
    idle_m   = MW'(idle_q4) + MW'(idle_rem >= AW'(fdrs_pkg::IDLE_DEN));
    eye_m    = glare4 ? MW'(fdrs_pkg::GLARE_EYE_Q16) : m4_eye;
    max_next = m4_steer;
    if (eye_m > max_next) begin
      max_next = eye_m;
    end
    if (m4_hands > max_next) begin
      max_next = m4_hands;
    end
    if (idle_m > max_next) begin
      max_next = idle_m;
    end
    if (m4_head > max_next) begin
      max_next = m4_head;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      maxm5 <= max_next;
    end
  end

  // Stage 6: floor(max * 100 / 2^16)
  logic [SPW-1:0] score_prod;
  logic [fdrs_pkg::SCORE_W-1:0] risk;

  assign score_prod = SPW'(maxm5) * SPW'(fdrs_pkg::SCORE_SCALE);

  always_ff @(posedge clk) begin
    if (adv) begin
      risk <= score_prod[QB+fdrs_pkg::SCORE_W-1:QB];
    end
  end

  assign score.risk_score = risk;

  `FDRS_ASSERT(a_score_range,
    score.valid |-> score.risk_score <= fdrs_pkg::SCORE_W'(fdrs_pkg::SCORE_SCALE))
  `FDRS_ASSERT(a_glare_floor,
    (vld[3] && glare4 && adv) |=> maxm5 >= MW'(fdrs_pkg::GLARE_EYE_Q16))
  `FDRS_ASSERT(a_stall_holds_valid, !adv |=> $stable(vld))
  `FDRS_ASSERT_ALWAYS(a_reset_empties, rst |=> vld == '0)

endmodule
